/* design/ptt_pkg.sv */
// Package: shared types, codes and helpers for the port trigger table.
package ptt_pkg;

  typedef enum logic [1:0] {
    OP_OUT  = 2'd0,
    OP_IN   = 2'd1,
    OP_DNAT = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    VERDICT_CONTINUE = 2'd0,
    VERDICT_ACCEPT   = 2'd1,
    VERDICT_DNAT     = 2'd2
  } verdict_t;

  localparam logic [1:0]  RULE_TCP      = 2'd0;
  localparam logic [1:0]  RULE_UDP      = 2'd1;
  localparam logic [1:0]  RULE_BOTH     = 2'd2;
  localparam logic [7:0]  PROTO_NUM_TCP = 8'd6;
  localparam logic [7:0]  PROTO_NUM_UDP = 8'd17;
  localparam logic [15:0] TIMEOUT_RESET = 16'd120;
  localparam logic        REG_TIMEOUT   = 1'b0;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [1:0]  proto;
    logic [15:0] mport_lo;
    logic [15:0] mport_hi;
    logic [15:0] rport_lo;
    logic [15:0] rport_hi;
    logic        reply_seen;
    logic [15:0] countdown;
  } entry_t;

  function automatic logic proto_hit(input logic [1:0] ep, input logic [7:0] pp);
    logic r;
    unique case (ep)
      RULE_BOTH: r = 1'b1;
      RULE_TCP:  r = (pp == PROTO_NUM_TCP);
      RULE_UDP:  r = (pp == PROTO_NUM_UDP);
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* design/ptt_if.sv */
// Interfaces: request and response channels of the port trigger table.
interface ptt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  pkt_proto;
  logic [15:0] dest_port;
  logic [31:0] src_addr;
  logic [1:0]  rule_proto;
  logic [15:0] rule_mport_lo;
  logic [15:0] rule_mport_hi;
  logic [15:0] rule_rport_lo;
  logic [15:0] rule_rport_hi;
  modport source (output valid, op, pkt_proto, dest_port, src_addr, rule_proto,
                  rule_mport_lo, rule_mport_hi, rule_rport_lo, rule_rport_hi,
                  input ready);
  modport sink (input valid, op, pkt_proto, dest_port, src_addr, rule_proto,
                rule_mport_lo, rule_mport_hi, rule_rport_lo, rule_rport_hi,
                output ready);
endinterface

interface ptt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [31:0] dnat_addr;
  logic        table_full;
  modport source (output valid, verdict, dnat_addr, table_full, input ready);
  modport sink (input valid, verdict, dnat_addr, table_full, output ready);
endinterface

/* design/ptt_mem.sv */
// Entry memory: one write port, one registered read port.
module ptt_mem #(
  parameter int ENTRIES = 16,
  parameter int IW = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IW-1:0]   waddr,
  input  ptt_pkg::entry_t wdata,
  input  logic            re,
  input  logic [IW-1:0]   raddr,
  output ptt_pkg::entry_t rdata
);
  ptt_pkg::entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* design/ptt_cfg.sv */
// APB configuration register block.
module ptt_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] timeout_ticks
);
  logic sel0;
  assign sel0   = (paddr[2] == ptt_pkg::REG_TIMEOUT) && (paddr[1:0] == 2'd0);
  assign pready = 1'b1;
  assign prdata = sel0 ? {16'd0, timeout_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= ptt_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && sel0) begin
      timeout_ticks <= pwdata[15:0];
    end
  end
endmodule

/* design/port_trigger_table.sv */
// Port trigger table top level.
// Each transaction sweeps the table with one memory read per entry on the
// single read port; a new request is taken only in the idle state, once the
// previous result has been issued. Non TCP/UDP packets other than ticks skip
// the sweep. A stalled result holds off the next request.
// Reset (rst, synchronous) clears all valid bits and restores timeout to 120.
module port_trigger_table #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  ptt_req_if.sink     req,
  ptt_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  logic [15:0] timeout_ticks;

  logic [1:0]  op;
  logic [7:0]  pkt_proto;
  logic [15:0] port;
  logic [31:0] src_addr;
  logic [1:0]  rule_proto;
  logic [15:0] mlo, mhi, rlo, rhi;
  logic        active;

  logic [IW:0]   cnt;
  logic          ev_valid;
  logic [IW-1:0] ev_idx;
  logic          found;
  logic [IW-1:0] best_idx;
  logic [IW-1:0] best_rank;
  ptt_pkg::entry_t best_rec;
  logic          free_found;
  logic [IW-1:0] free_idx;

  logic [ENTRIES-1:0] valid;
  logic [IW-1:0] rank [ENTRIES];

  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr;
  ptt_pkg::entry_t mem_wdata, rd;

  logic accept, out_free, fin_go;
  logic ev_match, ev_expire, ev_tick;
  logic [15:0] lo, hi;
  logic do_insert, do_update;
  ptt_pkg::entry_t new_rec, upd_rec;
  logic [1:0]  v_next;
  logic [31:0] a_next;
  logic        f_next;

  ptt_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .timeout_ticks
  );

  ptt_mem #(.ENTRIES(ENTRIES), .IW(IW)) u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(cnt[IW-1:0]), .rdata(rd)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign fin_go    = (state == S_FINISH) && out_free;
  assign mem_re    = (state == S_SCAN) && (cnt < (IW+1)'(ENTRIES));

  always_comb begin
    lo = (op == ptt_pkg::OP_OUT) ? rd.mport_lo : rd.rport_lo;
    hi = (op == ptt_pkg::OP_OUT) ? rd.mport_hi : rd.rport_hi;
    ev_match  = ev_valid && valid[ev_idx] && (op != ptt_pkg::OP_TICK)
                && ptt_pkg::proto_hit(rd.proto, pkt_proto)
                && (lo <= port) && (port <= hi);
    ev_tick   = ev_valid && valid[ev_idx] && (op == ptt_pkg::OP_TICK);
    ev_expire = ev_tick && (rd.countdown <= 16'd1);
  end

  always_comb begin
    new_rec.src_addr   = src_addr;
    new_rec.proto      = rule_proto;
    new_rec.mport_lo   = mlo;
    new_rec.mport_hi   = (mhi == 16'd0) ? mlo : mhi;
    new_rec.rport_lo   = rlo;
    new_rec.rport_hi   = (rhi == 16'd0) ? rlo : rhi;
    new_rec.reply_seen = 1'b0;
    new_rec.countdown  = timeout_ticks;
    upd_rec   = best_rec;
    do_insert = 1'b0;
    do_update = 1'b0;
    v_next    = ptt_pkg::VERDICT_CONTINUE;
    a_next    = 32'd0;
    f_next    = 1'b0;
    if (active) begin
      unique case (op)
        ptt_pkg::OP_OUT: begin
          if (found) begin
            do_update = 1'b1;
            upd_rec.countdown = timeout_ticks;
            if (best_rec.reply_seen) begin
              upd_rec.src_addr = src_addr;
            end
          end else if (free_found) begin
            do_insert = 1'b1;
          end else begin
            f_next = 1'b1;
          end
        end
        ptt_pkg::OP_IN: begin
          if (found) begin
            do_update = 1'b1;
            upd_rec.countdown = timeout_ticks;
            v_next = ptt_pkg::VERDICT_ACCEPT;
          end
        end
        ptt_pkg::OP_DNAT: begin
          if (found && (best_rec.src_addr != 32'd0)) begin
            do_update = 1'b1;
            upd_rec.reply_seen = 1'b1;
            v_next = ptt_pkg::VERDICT_DNAT;
            a_next = best_rec.src_addr;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ev_idx;
    mem_wdata = rd;
    if (ev_tick && !ev_expire) begin
      mem_we = 1'b1;
      mem_wdata.countdown = rd.countdown - 16'd1;
    end else if (fin_go && do_insert) begin
      mem_we    = 1'b1;
      mem_waddr = free_idx;
      mem_wdata = new_rec;
    end else if (fin_go && do_update) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx;
      mem_wdata = upd_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= req.op;
      pkt_proto  <= req.pkt_proto;
      port       <= req.dest_port;
      src_addr   <= req.src_addr;
      rule_proto <= req.rule_proto;
      mlo        <= req.rule_mport_lo;
      mhi        <= req.rule_mport_hi;
      rlo        <= req.rule_rport_lo;
      rhi        <= req.rule_rport_hi;
      active     <= (req.op == ptt_pkg::OP_TICK) || (req.pkt_proto == ptt_pkg::PROTO_NUM_TCP)
                    || (req.pkt_proto == ptt_pkg::PROTO_NUM_UDP);
    end
    if (accept) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (ev_valid) begin
      if (ev_match && (!found || rank[ev_idx] < best_rank)) begin
        found     <= 1'b1;
        best_idx  <= ev_idx;
        best_rank <= rank[ev_idx];
        best_rec  <= rd;
      end
      if (!valid[ev_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= ev_idx;
      end
    end
    ev_idx <= cnt[IW-1:0];
    for (int j = 0; j < ENTRIES; j++) begin
      if (fin_go && do_insert) begin
        if (IW'(j) == free_idx) begin
          rank[j] <= '0;
        end else if (valid[j]) begin
          rank[j] <= rank[j] + 1'b1;
        end
      end else if (ev_expire && valid[j] && (rank[j] > rank[ev_idx])) begin
        rank[j] <= rank[j] - 1'b1;
      end
    end
    if (fin_go) begin
      rsp.verdict    <= v_next;
      rsp.dnat_addr  <= a_next;
      rsp.table_full <= f_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ev_valid  <= 1'b0;
      valid     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      ev_valid <= mem_re;
      if (ev_expire) begin
        valid[ev_idx] <= 1'b0;
      end
      if (fin_go && do_insert) begin
        valid[free_idx] <= 1'b1;
      end
      if (fin_go) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            if ((req.op == ptt_pkg::OP_TICK) || (req.pkt_proto == ptt_pkg::PROTO_NUM_TCP)
                || (req.pkt_proto == ptt_pkg::PROTO_NUM_UDP)) begin
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (mem_re) begin
            cnt <= cnt + 1'b1;
          end
          if (ev_valid && (ev_idx == IW'(ENTRIES - 1))) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/ptt_checker.sv */
// Port-level checker for the port trigger table, bound to the top level.
module ptt_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  verdict,
  input logic [31:0] dnat_addr,
  input logic        table_full
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (verdict != ptt_pkg::VERDICT_DNAT) |-> dnat_addr == 32'd0)
    else $error("dnat_addr nonzero without rewrite");

  a_full_cont: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && table_full |-> verdict == ptt_pkg::VERDICT_CONTINUE)
    else $error("table_full with non-continue verdict");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(verdict) && $stable(dnat_addr))
    else $error("stalled response changed");
endmodule

bind port_trigger_table ptt_checker u_ptt_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .verdict(rsp.verdict), .dnat_addr(rsp.dnat_addr), .table_full(rsp.table_full)
);

/* bench/ptt_tb_if.sv */
// Testbench-side note: channel interfaces come from the design; this file holds the bench helpers.
`timescale 1ns / 1ps
package ptt_tb_pkg;

  typedef struct packed {
    ptt_pkg::op_t op;
    logic [7:0]  pkt_proto;
    logic [15:0] dest_port;
    logic [31:0] src_addr;
    logic [1:0]  rule_proto;
    logic [15:0] mport_lo;
    logic [15:0] mport_hi;
    logic [15:0] rport_lo;
    logic [15:0] rport_hi;
  } pkt_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] dnat_addr;
    logic        table_full;
  } outcome_t;
endpackage

/* bench/port_trigger_table_tb.sv */
// Testbench for the port trigger table: random and directed packets, self-checking.
`timescale 1ns / 1ps
module port_trigger_table_tb;

  localparam int NENT = 16;
  localparam int WATCHDOG = 20000;
  localparam int LONG_HOLD = 400;
  localparam logic [1:0] RULE_NOMATCH = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ptt_req_if req();
  ptt_rsp_if rsp();

  port_trigger_table #(.ENTRIES(NENT)) dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow table
  logic        t_valid [NENT] = '{default: 1'b0};
  logic [31:0] t_addr [NENT];
  logic [1:0]  t_proto [NENT];
  logic [15:0] t_mlo [NENT], t_mhi [NENT], t_rlo [NENT], t_rhi [NENT];
  logic        t_reply [NENT];
  logic [15:0] t_count [NENT];
  int          t_rank [NENT] = '{default: 0};
  logic [15:0] timeout_ticks = ptt_pkg::TIMEOUT_RESET;

  ptt_tb_pkg::pkt_t     pending_pkts[$];
  ptt_tb_pkg::outcome_t expected_outcomes[$];
  int       errors = 0;
  int       accepted_pkts = 0;
  int       checked = 0;
  int       send_idle_pct = 0, recv_idle_pct = 0;
  int       hold_cycles;
  logic     hold_arm = 1'b0;
  logic     hold_taken;
  int       quiet_cycles = 0;

  function automatic logic proto_match(logic [1:0] ep, logic [7:0] pp);
    if (ep == ptt_pkg::RULE_BOTH) return 1'b1;
    if (ep == ptt_pkg::RULE_TCP) return pp == ptt_pkg::PROTO_NUM_TCP;
    if (ep == ptt_pkg::RULE_UDP) return pp == ptt_pkg::PROTO_NUM_UDP;
    return 1'b0;
  endfunction

  function automatic int find_newest(logic related, logic [7:0] pp, logic [15:0] port);
    int best;
    logic [15:0] lo, hi;
    best = -1;
    for (int i = 0; i < NENT; i++) begin
      if (t_valid[i] && proto_match(t_proto[i], pp)) begin
        lo = related ? t_rlo[i] : t_mlo[i];
        hi = related ? t_rhi[i] : t_mhi[i];
        if (lo <= port && port <= hi)
          if (best < 0 || t_rank[i] < t_rank[best]) best = i;
      end
    end
    return best;
  endfunction

  function automatic ptt_tb_pkg::outcome_t predict_verdict(ptt_tb_pkg::pkt_t p);
    ptt_tb_pkg::outcome_t o;
    int hit, slot;
    o = '0;
    if (p.op == ptt_pkg::OP_TICK) begin
      for (int i = 0; i < NENT; i++) begin
        if (t_valid[i]) begin
          if (t_count[i] <= 16'd1) begin
            t_valid[i] = 1'b0;
            for (int j = 0; j < NENT; j++)
              if (t_valid[j] && t_rank[j] > t_rank[i]) t_rank[j]--;
          end else begin
            t_count[i]--;
          end
        end
      end
    end else if (p.pkt_proto == ptt_pkg::PROTO_NUM_TCP
                 || p.pkt_proto == ptt_pkg::PROTO_NUM_UDP) begin
      if (p.op == ptt_pkg::OP_OUT) begin
        hit = find_newest(1'b0, p.pkt_proto, p.dest_port);
        if (hit >= 0) begin
          t_count[hit] = timeout_ticks;
          if (t_reply[hit]) t_addr[hit] = p.src_addr;
        end else begin
          slot = -1;
          for (int i = 0; i < NENT; i++)
            if (!t_valid[i] && slot < 0) slot = i;
          if (slot < 0) begin
            o.table_full = 1'b1;
          end else begin
            for (int i = 0; i < NENT; i++) if (t_valid[i]) t_rank[i]++;
            t_valid[slot] = 1'b1;
            t_addr[slot] = p.src_addr;
            t_proto[slot] = p.rule_proto;
            t_mlo[slot] = p.mport_lo;
            t_mhi[slot] = (p.mport_hi == 16'd0) ? p.mport_lo : p.mport_hi;
            t_rlo[slot] = p.rport_lo;
            t_rhi[slot] = (p.rport_hi == 16'd0) ? p.rport_lo : p.rport_hi;
            t_reply[slot] = 1'b0;
            t_count[slot] = timeout_ticks;
            t_rank[slot] = 0;
          end
        end
      end else if (p.op == ptt_pkg::OP_IN) begin
        hit = find_newest(1'b1, p.pkt_proto, p.dest_port);
        if (hit >= 0) begin
          t_count[hit] = timeout_ticks;
          o.verdict = ptt_pkg::VERDICT_ACCEPT;
        end
      end else begin
        hit = find_newest(1'b1, p.pkt_proto, p.dest_port);
        if (hit >= 0 && t_addr[hit] != 32'd0) begin
          t_reply[hit] = 1'b1;
          o.verdict = ptt_pkg::VERDICT_DNAT;
          o.dnat_addr = t_addr[hit];
        end
      end
    end
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (req.valid) accepted_pkts <= accepted_pkts + 1;
      if (pending_pkts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        ptt_tb_pkg::pkt_t p;
        p = pending_pkts.pop_front();
        expected_outcomes.push_back(predict_verdict(p));
        req.valid <= 1'b1;
        req.op <= p.op;
        req.pkt_proto <= p.pkt_proto;
        req.dest_port <= p.dest_port;
        req.src_addr <= p.src_addr;
        req.rule_proto <= p.rule_proto;
        req.rule_mport_lo <= p.mport_lo;
        req.rule_mport_hi <= p.mport_hi;
        req.rule_rport_lo <= p.rport_lo;
        req.rule_rport_hi <= p.rport_hi;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off once armed
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_cycles <= 0;
      hold_taken <= 1'b0;
    end else if (hold_arm && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= LONG_HOLD;
      rsp.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_outcomes.size() == 0) begin
        $error("unexpected transaction: verdict %0d addr %h full %0b",
               rsp.verdict, rsp.dnat_addr, rsp.table_full);
        errors <= errors + 1;
      end else begin
        ptt_tb_pkg::outcome_t e;
        int bad;
        e = expected_outcomes.pop_front();
        bad = 0;
        if (rsp.verdict !== e.verdict) begin
          $error("verdict: expected %0d got %0d", e.verdict, rsp.verdict);
          bad++;
        end
        if (rsp.dnat_addr !== e.dnat_addr) begin
          $error("dnat_addr: expected %h got %h", e.dnat_addr, rsp.dnat_addr);
          bad++;
        end
        if (rsp.table_full !== e.table_full) begin
          $error("table_full: expected %0b got %0b", e.table_full, rsp.table_full);
          bad++;
        end
        errors <= errors + bad;
      end
      checked <= checked + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_timeout(logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {ptt_pkg::REG_TIMEOUT, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    timeout_ticks = val;
  endtask

  task automatic drain();
    wait (pending_pkts.size() == 0);
    @(posedge clk);
    while (req.valid || expected_outcomes.size() > 0) @(posedge clk);
    repeat (NENT + 8) @(posedge clk);
  endtask

  task automatic add(ptt_pkg::op_t op, logic [7:0] pp, logic [15:0] port, logic [31:0] a,
                     logic [1:0] rp, logic [15:0] mlo, logic [15:0] mhi,
                     logic [15:0] rlo, logic [15:0] rhi);
    ptt_tb_pkg::pkt_t p;
    p.op = op; p.pkt_proto = pp; p.dest_port = port; p.src_addr = a;
    p.rule_proto = rp; p.mport_lo = mlo; p.mport_hi = mhi;
    p.rport_lo = rlo; p.rport_hi = rhi;
    pending_pkts.push_back(p);
  endtask

  function automatic logic [7:0] rand_proto();
    int r;
    r = $urandom_range(9);
    if (r < 5) return ptt_pkg::PROTO_NUM_TCP;
    if (r < 9) return ptt_pkg::PROTO_NUM_UDP;
    return 8'($urandom_range(255));
  endfunction

  // rule-based sessions: trigger, related traffic, dnat, ticks
  task automatic add_random(int n);
    logic [15:0] base, rbase;
    logic [31:0] a;
    for (int k = 0; k < n; k++) begin
      int r;
      r = $urandom_range(99);
      base = 16'($urandom_range(7) * 1000 + $urandom_range(40));
      rbase = 16'(16'hF000 + $urandom_range(15) * 64);
      a = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
      if (r < 30) begin
        add(ptt_pkg::OP_OUT, rand_proto(), 16'(base + $urandom_range(10)), a,
            2'($urandom_range(3)), base,
            ($urandom_range(4) == 0) ? 16'd0 : 16'(base + 16'd10),
            rbase, ($urandom_range(4) == 0) ? 16'd0 : 16'(rbase + $urandom_range(63)));
      end else if (r < 50) begin
        add(ptt_pkg::OP_IN, rand_proto(), 16'(rbase + $urandom_range(63)), $urandom,
            2'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom));
      end else if (r < 70) begin
        add(ptt_pkg::OP_DNAT, rand_proto(), 16'(rbase + $urandom_range(63)), $urandom,
            2'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom));
      end else if (r < 85) begin
        add(ptt_pkg::OP_TICK, 8'($urandom), 16'($urandom), $urandom,
            2'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom));
      end else begin
        add(ptt_pkg::op_t'($urandom_range(3)), 8'($urandom), 16'($urandom), $urandom,
            2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    send_idle_pct = 7; recv_idle_pct = 88;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed
    add(ptt_pkg::OP_OUT, ptt_pkg::PROTO_NUM_TCP, 16'd100, 32'hFFFFFFFF, ptt_pkg::RULE_TCP,
        16'd100, 16'd0, 16'd5000, 16'd0);
    add(ptt_pkg::OP_OUT, ptt_pkg::PROTO_NUM_UDP, 16'hFFFF, 32'h0, ptt_pkg::RULE_BOTH,
        16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    add(ptt_pkg::OP_OUT, ptt_pkg::PROTO_NUM_UDP, 16'd7, 32'h1234, RULE_NOMATCH,
        16'd7, 16'd7, 16'd8, 16'd8);
    add(ptt_pkg::OP_OUT, ptt_pkg::PROTO_NUM_TCP, 16'd300, 32'h55, ptt_pkg::RULE_UDP,
        16'd400, 16'd300, 16'd600, 16'd500);
    add(ptt_pkg::OP_OUT, 8'd1, 16'd100, 32'h1, ptt_pkg::RULE_TCP,
        16'd0, 16'd0, 16'd0, 16'd0);
    add(ptt_pkg::OP_IN, ptt_pkg::PROTO_NUM_TCP, 16'd5000, 32'h0, ptt_pkg::RULE_TCP,
        16'd0, 16'd0, 16'd0, 16'd0);
    add(ptt_pkg::OP_IN, 8'hFF, 16'd5000, 32'h0, ptt_pkg::RULE_TCP,
        16'd0, 16'd0, 16'd0, 16'd0);
    add(ptt_pkg::OP_DNAT, ptt_pkg::PROTO_NUM_TCP, 16'd5000, 32'h0, ptt_pkg::RULE_TCP,
        16'd0, 16'd0, 16'd0, 16'd0);
    add(ptt_pkg::OP_DNAT, ptt_pkg::PROTO_NUM_UDP, 16'd1, 32'h0, ptt_pkg::RULE_TCP,
        16'd0, 16'd0, 16'd0, 16'd0);
    add(ptt_pkg::OP_DNAT, ptt_pkg::PROTO_NUM_UDP, 16'd8, 32'h0, ptt_pkg::RULE_TCP,
        16'd0, 16'd0, 16'd0, 16'd0);
    add(ptt_pkg::OP_OUT, ptt_pkg::PROTO_NUM_TCP, 16'd100, 32'hA5A5A5A5, ptt_pkg::RULE_TCP,
        16'd0, 16'd0, 16'd0, 16'd0);
    add(ptt_pkg::OP_DNAT, ptt_pkg::PROTO_NUM_TCP, 16'd5000, 32'h0, ptt_pkg::RULE_TCP,
        16'd0, 16'd0, 16'd0, 16'd0);
    for (int i = 0; i < 14; i++)
      add(ptt_pkg::OP_OUT, ptt_pkg::PROTO_NUM_TCP, 16'(20000 + i), 32'(32'h100 + i),
          ptt_pkg::RULE_TCP, 16'(20000 + i), 16'd0, 16'(30000 + i), 16'd0);
    drain();
    write_timeout(16'd2);
    for (int i = 0; i < 3; i++) add(ptt_pkg::OP_TICK, 8'hFF, 16'hFFFF, 32'hFFFFFFFF,
                                    RULE_NOMATCH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    write_timeout(16'd1);
    add_random(250);
    drain();
    write_timeout(16'd0);
    add_random(100);
    drain();

    send_idle_pct = 88; recv_idle_pct = 7;
    write_timeout(16'hFFFF);
    add_random(300);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_timeout(16'd20);
    hold_arm = 1'b1;
    add_random(350);
    drain();
    write_timeout(16'd5);
    add_random(330);
    drain();

    $display("Ran %0d transactions, %0d results checked, across seven timeout values",
             accepted_pkts, checked);
    $display("including full-table, expiry, dnat and non-TCP/UDP traffic.");
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
